// File: src/loadcell_baseline_trigger_defines.svh
// Assertion macros for the load-cell trigger checker
`ifndef LOADCELL_BASELINE_TRIGGER_DEFINES_SVH
`define LOADCELL_BASELINE_TRIGGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LBT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lbt_pkg.sv
// Shared types and constants for the load-cell baseline trigger
`timescale 1ns / 1ps

package lbt_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int BASE_W      = 24;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int IN_PAD_W    = IN_TDATA_W - SAMPLE_W - 1;
    localparam int OUT_PAD_W   = OUT_TDATA_W - BASE_W - 2;

    // Output tdata bit positions
    localparam int TRIG_BIT  = 0;
    localparam int READY_BIT = 1;
    localparam int BASE_LSB  = 2;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CLEAR  = 1'b1
    } cmd_t;

    // Direction of the trigger compare, decoded from the threshold sign
    typedef struct packed {
        logic pos;
        logic neg;
    } thr_flags_t;

    // Per-transaction status carried down the pipeline
    typedef struct packed {
        logic triggered;
        logic ready;
    } win_status_t;

endpackage

// File: src/lbt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps

module lbt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 200
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/lbt_window.sv
// Sample window: input register, ring buffer, running sum and trigger compare
`timescale 1ns / 1ps

module lbt_window #(
    parameter int WINDOW = 200
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  lbt_pkg::cmd_t                                    in_cmd,
    input  logic signed [lbt_pkg::SAMPLE_W-1:0]              in_sample,
    input  logic                                             in_update,
    input  lbt_pkg::thr_flags_t                              thr_flags,
    input  logic signed [lbt_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] thr_scaled,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output lbt_pkg::win_status_t                             out_status,
    output logic signed [lbt_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] out_sum
);

    import lbt_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int CMP_W  = SUM_W + 1;
    localparam int EXT_W  = SUM_W - SAMPLE_W;
    localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(WINDOW);
    localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(WINDOW - 1);

    // Input register
    logic                    s0_valid_reg;
    cmd_t                    s0_cmd_reg;
    logic signed [SAMPLE_W-1:0] s0_sample_reg;
    logic signed [SUM_W-1:0] s0_scaled_reg;
    logic                    s0_update_reg;
    logic signed [SUM_W-1:0] s0_scaled_next;
    logic signed [SUM_W-1:0] in_sample_ext;

    // Result register
    logic                    s1_valid_reg;
    win_status_t             s1_status_reg;
    logic signed [SUM_W-1:0] s1_sum_reg;
    win_status_t             s1_status_next;

    // Window state
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [ADDR_W-1:0]       wp_reg;
    logic [ADDR_W-1:0]       wp_next;

    logic                    s1_ready;
    logic                    load;
    logic                    fire;
    logic                    full;
    logic                    is_clear;
    logic                    push;
    logic [SAMPLE_W-1:0]     ram_rdata;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] cur_ext;
    logic signed [CMP_W-1:0] lhs;
    logic signed [CMP_W-1:0] rhs;
    logic                    trig;

    assign s1_ready = !s1_valid_reg || out_ready;
    assign in_ready = !s0_valid_reg || s1_ready;
    assign load     = in_valid && in_ready;
    assign fire     = s0_valid_reg && s1_ready;

    assign in_sample_ext  = {{EXT_W{in_sample[SAMPLE_W-1]}}, in_sample};
    assign s0_scaled_next = in_sample_ext * WIN_S;

    always_comb
    begin
        full     = (cnt_reg == CNT_FULL);
        is_clear = (s0_cmd_reg == CMD_CLEAR);
        push     = !is_clear && (!full || s0_update_reg);

        cur_ext = {{EXT_W{s0_sample_reg[SAMPLE_W-1]}}, s0_sample_reg};
        old_ext = full ? {{EXT_W{ram_rdata[SAMPLE_W-1]}}, $signed(ram_rdata)} : '0;

        lhs  = {s0_scaled_reg[SUM_W-1], s0_scaled_reg};
        rhs  = {sum_reg[SUM_W-1], sum_reg} + {thr_scaled[SUM_W-1], thr_scaled};
        trig = !is_clear && full
               && ((thr_flags.pos && (lhs > rhs)) || (thr_flags.neg && (lhs < rhs)));

        sum_next = sum_reg;
        cnt_next = cnt_reg;
        wp_next  = wp_reg;
        if (fire)
        begin
            if (is_clear)
            begin
                sum_next = '0;
                cnt_next = '0;
                wp_next  = '0;
            end
            else if (push)
            begin
                sum_next = sum_reg + cur_ext - old_ext;
                cnt_next = full ? cnt_reg : cnt_reg + 1'b1;
                wp_next  = (wp_reg == POS_LAST) ? '0 : wp_reg + 1'b1;
            end
        end

        s1_status_next.triggered = trig;
        s1_status_next.ready     = (cnt_next == CNT_FULL);
    end

    // Read ahead at the next write position so the oldest entry is ready
    // for the following transaction.
    lbt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .wen   (fire && push),
        .waddr (wp_reg),
        .wdata (s0_sample_reg),
        .raddr (wp_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            wp_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s0_cmd_reg    <= in_cmd;
            s0_sample_reg <= in_sample;
            s0_scaled_reg <= s0_scaled_next;
            s0_update_reg <= in_update;
        end
        if (fire)
        begin
            s1_status_reg <= s1_status_next;
            s1_sum_reg    <= sum_next;
        end
    end

    assign out_valid  = s1_valid_reg;
    assign out_status = s1_status_reg;
    assign out_sum    = s1_sum_reg;

endmodule

// File: src/lbt_mean.sv
// Window mean: floor(sum / WINDOW) by reciprocal multiply and one correction
`timescale 1ns / 1ps

module lbt_mean #(
    parameter int WINDOW = 200
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  lbt_pkg::win_status_t                             in_status,
    input  logic signed [lbt_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] in_sum,
    output logic                                             m_axis_tvalid,
    input  logic                                             m_axis_tready,
    output logic [lbt_pkg::OUT_TDATA_W-1:0]                  m_axis_tdata
);

    import lbt_pkg::*;

    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
    localparam int RECIP_W = SUM_W - $clog2(WINDOW) + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int Q_W     = BASE_W;
    localparam int REM_W   = $clog2(WINDOW) + 1;
    localparam logic [PROD_W-1:0] RECIP  = PROD_W'((64'd1 << SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0]  OFFSET = SUM_W'(64'(WINDOW) << (SAMPLE_W - 1));
    localparam logic [SUM_W-1:0]  WIN_U  = SUM_W'(WINDOW);
    localparam logic [REM_W-1:0]  WIN_R  = REM_W'(WINDOW);

    // Stage A: bias the sum so it is never negative
    logic              a_valid_reg;
    win_status_t       a_status_reg;
    logic [SUM_W-1:0]  a_u_reg;
    // Stage B: reciprocal product
    logic              b_valid_reg;
    win_status_t       b_status_reg;
    logic [SUM_W-1:0]  b_u_reg;
    logic [PROD_W-1:0] b_prod_reg;
    // Stage C: estimate and remainder
    logic              c_valid_reg;
    win_status_t       c_status_reg;
    logic [Q_W-1:0]    c_q_reg;
    logic [REM_W-1:0]  c_rem_reg;
    // Stage D: output register
    logic              d_valid_reg;
    logic [OUT_TDATA_W-1:0] d_data_reg;

    logic              a_ready;
    logic              b_ready;
    logic              c_ready;
    logic              d_ready;
    logic [PROD_W-1:0] b_prod_next;
    logic [Q_W-1:0]    q_est;
    logic [SUM_W-1:0]  rem_full;
    logic [Q_W-1:0]    q_fix;
    logic [BASE_W-1:0] base_next;
    logic [OUT_TDATA_W-1:0] d_data_next;

    assign d_ready  = !d_valid_reg || m_axis_tready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        b_prod_next = {{RECIP_W{1'b0}}, a_u_reg} * RECIP;
        q_est       = b_prod_reg[SUM_W +: Q_W];
        rem_full    = b_u_reg - ({{(SUM_W - Q_W){1'b0}}, q_est} * WIN_U);
        // The estimate is low by at most one
        q_fix       = c_q_reg + Q_W'(c_rem_reg >= WIN_R);
        // Remove the bias: q - 2^23 is a flip of the top bit
        base_next   = c_status_reg.ready ? {~q_fix[Q_W-1], q_fix[Q_W-2:0]} : '0;
        d_data_next = {{OUT_PAD_W{1'b0}}, base_next,
                       c_status_reg.ready, c_status_reg.triggered};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_status_reg <= in_status;
            a_u_reg      <= in_sum + OFFSET;
        end
        if (b_ready && a_valid_reg)
        begin
            b_status_reg <= a_status_reg;
            b_u_reg      <= a_u_reg;
            b_prod_reg   <= b_prod_next;
        end
        if (c_ready && b_valid_reg)
        begin
            c_status_reg <= b_status_reg;
            c_q_reg      <= q_est;
            c_rem_reg    <= rem_full[REM_W-1:0];
        end
        if (d_ready && c_valid_reg)
        begin
            d_data_reg <= d_data_next;
        end
    end

    assign m_axis_tvalid = d_valid_reg;
    assign m_axis_tdata  = d_data_reg;

endmodule

// File: src/loadcell_baseline_trigger.sv
// Top level of the load-cell moving-average baseline trigger
`timescale 1ns / 1ps

// Load-cell baseline trigger.
// Input stream (s_axis): one transaction per converter reading or command.
//   tuser selects the command: sample, or clear the baseline window.
//   tdata carries the signed 24-bit sample and the baseline update flag.
// Output stream (m_axis): exactly one transaction per input transaction,
//   in order, with the trigger flag, the ready flag and floor(sum/WINDOW).
// Configuration: cfg_wen writes the signed 24-bit trigger threshold; write
//   it only while no transaction is in flight.
// Throughput: one transaction per cycle while m_axis is not stalled. The window
//   sum, fill count and ring position update together, and the ring RAM reads
//   the oldest entry ahead at the next write position so it is ready for the next sample.
// Pipeline: a result reaches m_axis through the input register, the window
//   result register, then three stages for the mean (bias, reciprocal
//   multiply, estimate and remainder) and the output register.
// Reset: the window is emptied and the threshold returns to zero; ring
//   contents are left as they are and are never read before written.
// Backpressure: a stalled m_axis holds its transaction; the pipeline keeps
//   accepting until every stage is full, then s_axis_tready drops.
module loadcell_baseline_trigger #(
    parameter int WINDOW = 200
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration: trigger threshold
    input  logic                            cfg_wen,
    input  logic [lbt_pkg::SAMPLE_W-1:0]    cfg_wdata,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lbt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [23:0] sample, [24] baseline_update
    input  logic                            s_axis_tuser,  // [0] command
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lbt_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [0] triggered, [1] baseline_ready,
                                                           // [25:2] baseline
);

    import lbt_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int EXT_W = SUM_W - SAMPLE_W;
    localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);

    // Threshold, kept pre-scaled by WINDOW so the compare needs no multiply
    thr_flags_t              thr_flags_reg;
    thr_flags_t              thr_flags_next;
    logic signed [SUM_W-1:0] thr_scaled_reg;
    logic signed [SUM_W-1:0] thr_scaled_next;
    logic signed [SUM_W-1:0] cfg_ext;

    logic                    win_valid;
    logic                    win_ready;
    win_status_t             win_status;
    logic signed [SUM_W-1:0] win_sum;

    always_comb
    begin
        cfg_ext              = {{EXT_W{cfg_wdata[SAMPLE_W-1]}}, $signed(cfg_wdata)};
        thr_scaled_next      = cfg_ext * WIN_S;
        // Sign picks the direction; zero disables the trigger
        thr_flags_next.neg   = cfg_wdata[SAMPLE_W-1];
        thr_flags_next.pos   = !cfg_wdata[SAMPLE_W-1] && (|cfg_wdata);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_flags_reg  <= '0;
            thr_scaled_reg <= '0;
        end
        else if (cfg_wen)
        begin
            thr_flags_reg  <= thr_flags_next;
            thr_scaled_reg <= thr_scaled_next;
        end
    end

    // Window update and trigger compare
    lbt_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (cmd_t'(s_axis_tuser)),
        .in_sample  ($signed(s_axis_tdata[SAMPLE_W-1:0])),
        .in_update  (s_axis_tdata[SAMPLE_W]),
        .thr_flags  (thr_flags_reg),
        .thr_scaled (thr_scaled_reg),
        .out_valid  (win_valid),
        .out_ready  (win_ready),
        .out_status (win_status),
        .out_sum    (win_sum)
    );

    // Baseline mean and output register
    lbt_mean #(
        .WINDOW (WINDOW)
    ) u_mean (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (win_valid),
        .in_ready      (win_ready),
        .in_status     (win_status),
        .in_sum        (win_sum),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: src/lbt_checker.sv
// Port-level checks for the load-cell baseline trigger, with its bind
`timescale 1ns / 1ps
`include "loadcell_baseline_trigger_defines.svh"

module lbt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lbt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import lbt_pkg::*;

    // Hold a stalled output transaction
    `LBT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output transaction changed while stalled")

    // A trigger is only raised against a full window
    `LBT_ASSERT_NOW(a_trig_needs_ready, m_axis_tvalid, !m_axis_tdata[TRIG_BIT] || m_axis_tdata[READY_BIT], "trigger without a full window")

    // Baseline reads zero until the window is full
    `LBT_ASSERT_NOW(a_base_zero, m_axis_tvalid && !m_axis_tdata[READY_BIT], m_axis_tdata[BASE_LSB +: BASE_W] == '0, "baseline nonzero while window not full")

    // With the output empty nothing can block the input
    `LBT_ASSERT_NOW(a_no_idle_stall, !m_axis_tvalid, s_axis_tready, "input stalled while output is empty")

endmodule

bind loadcell_baseline_trigger lbt_checker u_lbt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the load-cell moving-average baseline trigger
`timescale 1ns / 1ps

module tb_top;

    import lbt_pkg::*;

    localparam int WIN         = 200;
    localparam int SAMPLE_MAX  = 8388607;
    localparam int SAMPLE_MIN  = -8388608;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 190;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 20;

    // One expected output transaction
    typedef struct {
        bit                        trig;
        bit                        ready;
        logic signed [BASE_W-1:0]  base;
    } det_result_t;

    // Tracks the baseline window and the expected detector outputs
    class baseline_tracker;
        int          threshold;
        int          ring[WIN];
        longint      total;
        int          fill;
        int          wpos;
        det_result_t pending_results[$];
        int          errors;

        function new();
            threshold = 0;
            total     = 0;
            fill      = 0;
            wpos      = 0;
            errors    = 0;
        endfunction

        function void set_threshold(logic [SAMPLE_W-1:0] value);
            threshold = int'($signed(value));
        endfunction

        // Push one reading into the ring, dropping the oldest once full
        function void store(int smp);
            if (fill >= WIN)
                total -= ring[wpos];
            else
                fill++;
            ring[wpos] = smp;
            total += smp;
            wpos = (wpos + 1) % WIN;
        endfunction

        // Note one accepted input transaction and queue what it must produce
        function void note_reading(cmd_t cmd, logic [SAMPLE_W-1:0] raw, bit upd);
            det_result_t r;
            int          smp;
            longint      lhs;
            longint      rhs;
            longint      q;
            smp     = int'($signed(raw));
            r.trig  = 1'b0;
            r.ready = 1'b0;
            r.base  = '0;
            if (cmd == CMD_CLEAR) begin
                total = 0;
                fill  = 0;
                wpos  = 0;
                pending_results.push_back(r);
                return;
            end
            if (fill < WIN) begin
                store(smp);
            end
            else begin
                lhs = longint'(smp) * WIN;
                rhs = total + longint'(threshold) * WIN;
                if ((threshold > 0 && lhs > rhs) || (threshold < 0 && lhs < rhs))
                    r.trig = 1'b1;
                if (upd)
                    store(smp);
            end
            if (fill >= WIN) begin
                q = total / WIN;
                if ((total % WIN) != 0 && total < 0)
                    q--;
                r.ready = 1'b1;
                r.base  = q[BASE_W-1:0];
            end
            pending_results.push_back(r);
        endfunction

        // Compare one accepted output transaction with the oldest expectation
        function void check_result(logic [OUT_TDATA_W-1:0] data);
            det_result_t exp_r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (data[TRIG_BIT] !== exp_r.trig) begin
                $display("%0t: triggered expected %0b actual %0b",
                         $time, exp_r.trig, data[TRIG_BIT]);
                errors++;
            end
            if (data[READY_BIT] !== exp_r.ready) begin
                $display("%0t: baseline_ready expected %0b actual %0b",
                         $time, exp_r.ready, data[READY_BIT]);
                errors++;
            end
            if (data[BASE_LSB +: BASE_W] !== exp_r.base) begin
                $display("%0t: baseline expected %0d actual %0d", $time, exp_r.base,
                         $signed(data[BASE_LSB +: BASE_W]));
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wen;
    logic [SAMPLE_W-1:0]    cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    baseline_tracker tracker;
    bit              tx_burst;
    int              rx_count;
    int              idle_cycles;

    loadcell_baseline_trigger #(
        .WINDOW(WIN)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog: end the run once nothing has moved on either stream for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one transaction after a random gap; return at the falling edge after
    // acceptance with tvalid still high, so a zero gap keeps the stream busy.
    task automatic send_reading(cmd_t cmd, logic [SAMPLE_W-1:0] smp, bit upd);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{IN_PAD_W{1'b0}}, upd, smp};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_reading(cmd, smp, upd);
        @(negedge clk);
    endtask

    // Drop tvalid and wait until every expected result has come back
    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    // Write the threshold while the block is idle; only legal between phases
    task automatic write_threshold(int value);
        drain_stream();
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value[SAMPLE_W-1:0];
        tracker.set_threshold(value[SAMPLE_W-1:0]);
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // Draw a reading: mostly baseline plus noise, sometimes the rails or anything
    function automatic int draw_sample(int base, int amp);
        int v;
        case ($urandom_range(0, 19))
            0: v = int'($signed(24'($urandom)));
            1: v = SAMPLE_MAX;
            2: v = SAMPLE_MIN;
            default:
            begin
                v = base + int'($urandom_range(0, 2 * amp)) - amp;
                if (v > SAMPLE_MAX)
                    v = SAMPLE_MAX;
                if (v < SAMPLE_MIN)
                    v = SAMPLE_MIN;
            end
        endcase
        return v;
    endfunction

    // Receiver: random stalls, bursts with no stalls, and two long hold-offs that
    // let the pipeline fill so s_axis_tready must drop
    initial
    begin
        int stall;
        rx_count = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (rx_count == 500 || rx_count == 1300)
                stall = HOLD_CYCLES;
            else if ((rx_count / 150) % 3 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 7);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            tracker.check_result(m_axis_tdata);
            rx_count++;
            @(negedge clk);
        end
    end

    // Stimulus: directed corner cases, then phases of random readings under
    // a different threshold each
    initial
    begin
        int thr;
        int base;
        int amp;
        cmd_t cmd;

        tracker       = new();
        tx_burst      = 1'b0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: rails while filling with either update flag, clears that
        // carry a nonzero sample, and a clear on an empty window
        send_reading(CMD_CLEAR, 24'h000000, 1'b0);
        send_reading(CMD_SAMPLE, 24'h7FFFFF, 1'b0);
        send_reading(CMD_SAMPLE, 24'h800000, 1'b1);
        send_reading(CMD_SAMPLE, 24'h000000, 1'b0);
        send_reading(CMD_SAMPLE, 24'hFFFFFF, 1'b1);
        send_reading(CMD_SAMPLE, 24'h000001, 1'b0);
        send_reading(CMD_SAMPLE, 24'h555555, 1'b1);
        send_reading(CMD_SAMPLE, 24'hAAAAAA, 1'b0);
        send_reading(CMD_CLEAR, 24'h7FFFFF, 1'b1);
        send_reading(CMD_CLEAR, 24'h800000, 1'b0);
        send_reading(CMD_SAMPLE, 24'h800000, 1'b0);
        send_reading(CMD_SAMPLE, 24'h7FFFFF, 1'b1);
        send_reading(CMD_CLEAR, 24'hFFFFFF, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            amp  = $urandom_range(1, 1 << $urandom_range(0, 20));
            base = int'($signed(24'($urandom))) / 2;
            // Pick the threshold: both unit steps, the extremes, the most negative
            // value, zero, then random offsets near the noise
            case (p)
                0: thr = 1;
                1: thr = -1;
                2:
                begin
                    thr  = SAMPLE_MAX;
                    base = -int'($urandom_range(1, 4000000));
                end
                3:
                begin
                    thr  = -SAMPLE_MAX;
                    base = int'($urandom_range(1, 4000000));
                end
                4: thr = SAMPLE_MIN;
                5: thr = 0;
                default:
                begin
                    thr = int'($urandom_range(1, 2 * amp));
                    if ($urandom_range(0, 1) == 1)
                        thr = -thr;
                end
            endcase
            write_threshold(thr);
            tx_burst = (p % 3 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd = ($urandom_range(0, 249) == 0) ? CMD_CLEAR : CMD_SAMPLE;
                send_reading(cmd, 24'(draw_sample(base, amp)), $urandom_range(0, 3) != 0);
            end
        end

        // Wait out everything still in flight, then give stray outputs a chance
        drain_stream();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.outstanding() != 0) begin
            $display("%0t: %0d results never arrived", $time, tracker.outstanding());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
